// ===== design/spf_pkg.sv =====
// spf_pkg: shared widths and control/status types for the smallest prime factor unit
// used by spf_div and smallest_prime_factor_unit; no dependencies
`timescale 1ns / 1ps

package spf_pkg;

   // width of the value and factor ports
   localparam int PORT_BITS = 32;

   // default working width of the search datapath
   localparam int VALUE_BITS_DEFAULT = 32;

   // sequencer to divider
   typedef struct packed {
      logic start;
   } div_ctrl_type;

   // divider to sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ===== design/spf_div.sv =====
// spf_div: restoring divider, one quotient bit per cycle, quotient and remainder out
// depends on spf_pkg for the control and status structs
`timescale 1ns / 1ps

module spf_div #(
   parameter int WIDTH = spf_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  spf_pkg::div_ctrl_type ctrl,
   input  logic [WIDTH-1:0]     dividend,
   input  logic [WIDTH-1:0]     divisor,
   output spf_pkg::div_stat_type stat,
   output logic [WIDTH-1:0]     quotient,
   output logic [WIDTH-1:0]     remainder
);

   localparam int CNT_BITS = (WIDTH > 1) ? $clog2(WIDTH) : 1;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0]    quo_ff, quo_in;
   logic [WIDTH-1:0]    rem_ff, rem_in;
   logic [WIDTH+1:0]    trial;
   logic                last_step;

   // partial remainder with next dividend bit, minus divisor; top bit is the borrow
   assign trial     = {1'b0, rem_ff, quo_ff[WIDTH-1]} - {2'b00, divisor};
   assign last_step = (cnt_ff == CNT_BITS'(WIDTH - 1));

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (busy_ff) begin
         if (trial[WIDTH+1]) begin
            rem_in = {rem_ff[WIDTH-2:0], quo_ff[WIDTH-1]};
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         end else begin
            rem_in = trial[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b1};
         end
         cnt_in = cnt_ff + CNT_BITS'(1);
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (ctrl.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== design/smallest_prime_factor_unit.sv =====
// smallest_prime_factor_unit: trial division sequencer around one shared divider
// depends on spf_pkg and spf_div
`timescale 1ns / 1ps

// usage
//  - req channel: req_valid / req_stall / req_value, one beat per value to factor
//  - rsp channel: rsp_valid / rsp_stall / rsp_factor, one beat per accepted request
//  - only the low VALUE_BITS bits of req_value take part; rsp_factor is the low 32 bits
//  - divisors 2, 3, then 6k-1 and 6k+1 upward; the search ends when the divisor
//    exceeds value / divisor, and the value itself is returned as prime
//  - value zero gives 2, value one gives 0
//  - each trial divisor takes a start state, VALUE_BITS steps of the bit-serial
//    divider and a decision in the wait state
//  - trials is at most about sqrt(value) / 3 + 2, so near 21850 trials for a large
//    32-bit prime and 1 trial for an even value
//  - one request is in flight at a time: req_stall is high from acceptance until
//    the result is handed to the output register
//  - the output register lets a new request in while the last result still waits
//  - a stalled result holds in the output register; a finished search waits in
//    its final state until the output register is free
//  - synchronous reset drops any search in flight and empties the output register

module smallest_prime_factor_unit #(
   parameter int VALUE_BITS = spf_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [spf_pkg::PORT_BITS-1:0] req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [spf_pkg::PORT_BITS-1:0] rsp_factor
);

   // sequencer states
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_START = 2'd1;
   localparam logic [1:0] S_WAIT  = 2'd2;
   localparam logic [1:0] S_FIN   = 2'd3;

   // which divisor is under test
   localparam logic [1:0] STG_TWO   = 2'd0;
   localparam logic [1:0] STG_THREE = 2'd1;
   localparam logic [1:0] STG_LOW   = 2'd2;  // 6k-1, next step +2
   localparam logic [1:0] STG_HIGH  = 2'd3;  // 6k+1, next step +4

   logic [1:0]                    state_ff, state_in;
   logic [1:0]                    stage_ff, stage_in;
   logic [VALUE_BITS-1:0]         val_ff, val_in;
   logic [VALUE_BITS-1:0]         dvs_ff, dvs_in;
   logic [VALUE_BITS-1:0]         res_ff, res_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [spf_pkg::PORT_BITS-1:0] factor_ff, factor_in;

   spf_pkg::div_ctrl_type         div_ctrl;
   spf_pkg::div_stat_type         div_stat;
   logic [VALUE_BITS-1:0]         div_quo;
   logic [VALUE_BITS-1:0]         div_rem;
   logic                          req_beat;
   logic                          out_free;

   spf_div #(
      .WIDTH(VALUE_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (val_ff),
      .divisor  (dvs_ff),
      .stat     (div_stat),
      .quotient (div_quo),
      .remainder(div_rem)
   );

   assign req_stall      = (state_ff != S_IDLE);
   assign req_beat       = req_valid && !req_stall;
   assign out_free       = !rsp_valid_ff || !rsp_stall;
   assign div_ctrl.start = (state_ff == S_START);

   always_comb begin
      state_in     = state_ff;
      stage_in     = stage_ff;
      val_in       = val_ff;
      dvs_in       = dvs_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      factor_in    = factor_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               val_in   = VALUE_BITS'(req_value);
               dvs_in   = VALUE_BITS'(2);
               stage_in = STG_TWO;
               state_in = S_START;
            end
         end
         S_START: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (div_stat.done) begin
               state_in = S_START;
               case (stage_ff)
                  STG_TWO: begin
                     if (div_rem == '0) begin
                        res_in   = dvs_ff;
                        state_in = S_FIN;
                     end else begin
                        dvs_in   = VALUE_BITS'(3);
                        stage_in = STG_THREE;
                     end
                  end
                  STG_THREE: begin
                     if (div_rem == '0) begin
                        res_in   = dvs_ff;
                        state_in = S_FIN;
                     end else if (val_ff == VALUE_BITS'(1)) begin
                        // one has no prime factor
                        res_in   = '0;
                        state_in = S_FIN;
                     end else begin
                        dvs_in   = VALUE_BITS'(5);
                        stage_in = STG_LOW;
                     end
                  end
                  default: begin
                     if (dvs_ff > div_quo) begin
                        // divisor squared beyond value: value is prime
                        res_in   = val_ff;
                        state_in = S_FIN;
                     end else if (div_rem == '0) begin
                        res_in   = dvs_ff;
                        state_in = S_FIN;
                     end else if (stage_ff == STG_LOW) begin
                        dvs_in   = dvs_ff + VALUE_BITS'(2);
                        stage_in = STG_HIGH;
                     end else begin
                        dvs_in   = dvs_ff + VALUE_BITS'(4);
                        stage_in = STG_LOW;
                     end
                  end
               endcase
            end
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               factor_in    = spf_pkg::PORT_BITS'(res_ff);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         stage_ff     <= STG_TWO;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stage_ff     <= stage_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff    <= val_in;
      dvs_ff    <= dvs_in;
      res_ff    <= res_in;
      factor_ff <= factor_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_factor = factor_ff;

   // an accepted request always kicks off the first trial
   a_req_starts: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> (state_ff == S_START))
      else $error("accepted request did not start a trial");

   // divider results only arrive while the sequencer waits for them
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == S_WAIT))
      else $error("divider finished outside of wait state");

   // 6k-1 and 6k+1 divisors are always odd
   a_odd_divisor: assert property (@(posedge clock) disable iff (reset)
      ((state_ff != S_IDLE) && ((stage_ff == STG_LOW) || (stage_ff == STG_HIGH)))
      |-> dvs_ff[0])
      else $error("even trial divisor past three");

   // a new result only appears from the final state
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && !(rsp_valid_ff && rsp_stall)) |-> (state_ff == S_FIN))
      else $error("result loaded outside of final state");

endmodule

// ===== tb/smallest_prime_factor_unit_test.sv =====
// smallest_prime_factor_unit_test: self-checking bench for the trial division unit
// drives req beats, predicts each factor locally and checks rsp beats in order
// depends on spf_pkg and smallest_prime_factor_unit
`timescale 1ns / 1ps

module smallest_prime_factor_unit_test;

   localparam int PORT_BITS      = spf_pkg::PORT_BITS;
   // datapath width under test, and the cost of one trial divisor in cycles
   localparam int FACTOR_BITS    = spf_pkg::VALUE_BITS_DEFAULT;
   localparam int TRIAL_CYCLES   = FACTOR_BITS + 2;
   // a large 32-bit prime runs a long search with no beat on either side
   localparam int WATCHDOG_LIMIT = 3_000_000;
   localparam int REPORT_LIMIT   = 10;
   localparam int RANDOM_PER_PHASE = 17;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [PORT_BITS-1:0] req_value = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [PORT_BITS-1:0] rsp_factor;

   // factors still owed by the block, oldest first
   logic [PORT_BITS-1:0] expected_factors[$];

   // idling knobs, in cycles out of a hundred
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   // long receiver hold-off asked by a test, taken over by the receiver process
   int unsigned hold_off_request = 0;

   int unsigned values_sent    = 0;
   int unsigned factors_seen   = 0;
   int unsigned fail_count     = 0;
   int unsigned quiet_cycles   = 0;

   smallest_prime_factor_unit #(
      .VALUE_BITS(FACTOR_BITS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_value (req_value),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_factor(rsp_factor)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // smallest prime factor by 6k+-1 trial division on the low FACTOR_BITS bits
   // zero gives 2, one gives 0, a prime gives itself
   function automatic logic [PORT_BITS-1:0] smallest_factor_of(input logic [PORT_BITS-1:0] raw);
      bit [63:0] mask;
      bit [63:0] v;
      bit [63:0] d;
      bit [63:0] found;
      bit        done;
      mask  = (FACTOR_BITS >= 64) ? '1 : ((64'd1 << FACTOR_BITS) - 64'd1);
      v     = 64'(raw) & mask;
      done  = 1'b0;
      found = 64'd0;
      if (v % 64'd2 == 64'd0) begin
         found = 64'd2;
         done  = 1'b1;
      end else if (v % 64'd3 == 64'd0) begin
         found = 64'd3;
         done  = 1'b1;
      end else if (v == 64'd1) begin
         found = 64'd0;
         done  = 1'b1;
      end
      d = 64'd5;
      while (!done) begin
         // divisor 6k-1; the square test is done by division so it never overflows
         if (d > v / d) begin
            found = v;
            done  = 1'b1;
         end else if (v % d == 64'd0) begin
            found = d;
            done  = 1'b1;
         // divisor 6k+1
         end else if (d + 64'd2 > v / (d + 64'd2)) begin
            found = v;
            done  = 1'b1;
         end else if (v % (d + 64'd2) == 64'd0) begin
            found = d + 64'd2;
            done  = 1'b1;
         end
         d += 64'd6;
      end
      return found[PORT_BITS-1:0];
   endfunction

   // random value whose search stays short: a random 32-bit multiple of a small
   // number most of the time, otherwise a random value below 2^16 or 2^20
   function automatic logic [PORT_BITS-1:0] cheap_random_value();
      logic [PORT_BITS-1:0] x;
      int unsigned          mode;
      int unsigned          step;
      mode = $urandom_range(0, 9);
      x    = $urandom();
      step = $urandom_range(2, 97);
      if (mode < 6) begin
         return x - (x % step);
      end else if (mode < 9) begin
         return $urandom_range(0, 32'h0000_FFFF);
      end
      return $urandom_range(0, 32'h000F_FFFF);
   endfunction

   // one req beat: optional idle cycles first, then hold the value until accepted
   task automatic send_value(input logic [PORT_BITS-1:0] value);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      values_sent++;
   endtask

   // sender pause until every owed factor has come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_factors.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // receiver: random stall at the phase rate, or a long hold-off counted here
   always @(posedge clock) begin : receiver
      static int unsigned hold_left = 0;
      if (hold_off_request != 0) begin
         hold_left        = hold_off_request;
         hold_off_request = 0;
      end
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
      end
   end

   // scoreboard: predict on every req beat, compare on every rsp beat
   always @(posedge clock) begin : factor_check
      logic [PORT_BITS-1:0] want;
      if (!reset) begin
         if (req_valid && req_stall === 1'b0) begin
            expected_factors.push_back(smallest_factor_of(req_value));
         end
         if (rsp_valid === 1'b1 && !rsp_stall) begin
            factors_seen++;
            if (expected_factors.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT) begin
                  $display("unexpected rsp beat: factor 0x%08h", rsp_factor);
               end
            end else begin
               want = expected_factors.pop_front();
               if (rsp_factor !== want) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT) begin
                     $display("factor mismatch at beat %0d: expected %0d, got %0d",
                              factors_seen, want, rsp_factor);
                  end
               end
            end
         end
      end
   end

   // watchdog: cycles in a row with no beat on either channel
   always @(posedge clock) begin
      if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat for %0d cycles, %0d factors still owed",
                  quiet_cycles, expected_factors.size());
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // extremes of the field and the special values: zero, one, two, three,
   // squares and products of primes, all-ones patterns, a top-bit-only value
   task automatic test_corner_values();
      logic [PORT_BITS-1:0] corners[$];
      corners = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7, 32'd9,
                  32'd25, 32'd35, 32'd49, 32'd121, 32'd143, 32'd169, 32'd289,
                  32'd65521, 32'd63001, 32'd1022117, 32'h8000_0000, 32'hFFFF_FFFE,
                  32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAB};
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      foreach (corners[i]) begin
         send_value(corners[i]);
      end
      wait_for_drain();
   endtask

   // largest 32-bit prime: the longest search, run to the divisor square bound
   task automatic test_largest_prime();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_value(32'd4294967291);
      wait_for_drain();
   endtask

   // receiver holds off while the sender keeps offering, so the output register
   // fills, the finished search waits and req_stall stays up
   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      @(posedge clock);
      hold_off_request = 4000;
      for (int i = 0; i < 8; i++) begin
         send_value($urandom_range(0, 32'h0000_0FFF));
      end
      wait_for_drain();
   endtask

   // random values under one idling setting, then a drain
   task automatic test_random_values(input int unsigned idle_pct, input int unsigned stall_pct);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
         send_value(cheap_random_value());
      end
      wait_for_drain();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_corner_values();
      test_largest_prime();
      test_backpressure();
      test_random_values(0, 0);
      test_random_values(56, 0);
      test_random_values(0, 56);
      test_random_values(10, 10);

      // any late or extra rsp beat would show up as unexpected here
      repeat (2 * TRIAL_CYCLES) @(posedge clock);

      $display("sent %0d values (corners, the largest 32-bit prime, a long rsp hold-off,",
               values_sent);
      $display("random values under four idling mixes); %0d factors came back", factors_seen);
      if (fail_count == 0 && expected_factors.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d failures, %0d factors never came back",
                  fail_count, expected_factors.size());
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/spf_pkg.sv
design/spf_div.sv
design/smallest_prime_factor_unit.sv
tb/smallest_prime_factor_unit_test.sv
